/* sv/mtc_pkg.sv */
package mtc_pkg;

   typedef struct packed {
      logic       action;
      logic [6:0] qf_byte;
      logic [6:0] ff_rate_hours;
      logic [6:0] ff_minutes;
      logic [6:0] ff_seconds;
      logic [6:0] ff_frames;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  direction;
      logic [1:0]  rate_code;
      logic [4:0]  tc_hours;
      logic [6:0]  tc_minutes;
      logic [6:0]  tc_seconds;
      logic [6:0]  tc_frames;
      logic [62:0] sample_position;
   } rsp_type;

   localparam logic [1:0] ST_INCOMPLETE = 2'd0;
   localparam logic [1:0] ST_LOCKED     = 2'd1;
   localparam logic [1:0] ST_INVALID    = 2'd2;
   localparam logic [1:0] ST_DISCONT    = 2'd3;

   localparam logic [1:0] DIR_UNKNOWN = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   localparam logic [1:0] RATE_24   = 2'd0;
   localparam logic [1:0] RATE_25   = 2'd1;
   localparam logic [1:0] RATE_DROP = 2'd2;
   localparam logic [1:0] RATE_30   = 2'd3;

   localparam logic [0:0] CSR_RATE_NUM = 1'd0;
   localparam logic [0:0] CSR_RATE_DEN = 1'd1;

   localparam logic [31:0] RATE_NUM_RESET = 32'd48000;
   localparam logic [31:0] RATE_DEN_RESET = 32'd1;

   localparam logic [14:0] DROP_FR_NUM = 15'd30000;
   localparam logic [9:0]  DROP_FR_DEN = 10'd1001;

   typedef struct packed {
      logic       compute;
      logic [1:0] status;
      logic [1:0] dir;
      logic [1:0] rate;
      logic [4:0] h;
      logic [6:0] m;
      logic [6:0] s;
      logic [6:0] f;
   } dec_type;

   function automatic logic [4:0] nominal_fps(input logic [1:0] rate);
      logic [4:0] r;
      case (rate)
         RATE_24: r = 5'd24;
         RATE_25: r = 5'd25;
         default: r = 5'd30;
      endcase
      return r;
   endfunction

endpackage

/* sv/mtc_tracker.sv */
module mtc_tracker
   import mtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  logic    rate_ok,
   input  req_type req,
   output dec_type dec
);

   logic [3:0] store_ff [8];
   logic [3:0] store_nx [8];
   logic [7:0] rcv_ff, rcv_in;
   logic [2:0] prev_ff, prev_in;
   logic       seen_ff, seen_in;
   logic       clear;
   logic       wr_piece;

   logic [2:0] piece;
   logic [3:0] nib;
   logic [6:0] ffh_m;

   function automatic logic tc_valid(input logic [1:0] rate, input logic [4:0] h,
                                     input logic [6:0] m, input logic [6:0] s,
                                     input logic [6:0] f);
      logic ok;
      logic m10;
      ok = (h < 5'd24) && (m < 7'd60) && (s < 7'd60) && (f < {2'b00, nominal_fps(rate)});
      m10 = (m == 7'd0) || (m == 7'd10) || (m == 7'd20) || (m == 7'd30) ||
            (m == 7'd40) || (m == 7'd50);
      if (rate == RATE_DROP && s == 7'd0 && !m10 && f < 7'd2) begin
         ok = 1'b0;
      end
      return ok;
   endfunction

   assign piece = req.qf_byte[6:4];
   assign nib   = req.qf_byte[3:0];
   assign ffh_m = req.ff_rate_hours;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         store_nx[i] = (3'(i) == piece) ? nib : store_ff[i];
      end
   end

   always_comb begin
      logic [1:0] dir;
      logic       jump;
      logic       done;
      logic [7:0] rcv_or;
      dec      = '0;
      rcv_in   = rcv_ff;
      prev_in  = prev_ff;
      seen_in  = seen_ff;
      clear    = 1'b0;
      wr_piece = 1'b0;
      dir      = DIR_UNKNOWN;
      jump     = 1'b0;
      done     = 1'b0;
      rcv_or   = rcv_ff | (8'd1 << piece);
      if (!rate_ok) begin
         dec.status = ST_INVALID;
      end else if (req.action) begin
         dec.rate = ffh_m[6:5];
         dec.h    = ffh_m[4:0];
         dec.m    = req.ff_minutes;
         dec.s    = req.ff_seconds;
         dec.f    = req.ff_frames;
         if (tc_valid(dec.rate, dec.h, dec.m, dec.s, dec.f)) begin
            dec.compute = 1'b1;
            dec.status  = ST_LOCKED;
            clear       = 1'b1;
         end else begin
            dec     = '0;
            dec.status = ST_INVALID;
         end
      end else if (piece == 3'd7 && nib[3]) begin
         dec.status = ST_INVALID;
         clear      = 1'b1;
      end else begin
         wr_piece = 1'b1;
         prev_in  = piece;
         if (seen_ff) begin
            if (piece == prev_ff + 3'd1) begin
               dir = DIR_FORWARD;
            end else if (piece == prev_ff - 3'd1) begin
               dir = DIR_REVERSE;
            end else begin
               jump = 1'b1;
            end
         end
         if (jump) begin
            rcv_in     = 8'd1 << piece;
            dec.status = ST_DISCONT;
         end else begin
            seen_in = 1'b1;
            rcv_in  = rcv_or;
            done = (rcv_or == 8'hff) && ((dir == DIR_FORWARD && piece == 3'd7) ||
                                         (dir == DIR_REVERSE && piece == 3'd0));
            dec.dir = dir;
            if (!done) begin
               dec.status = ST_INCOMPLETE;
            end else begin
               rcv_in   = 8'd0;
               dec.rate = store_nx[7][2:1];
               dec.h    = {store_nx[7][0], store_nx[6]};
               dec.m    = {store_nx[5][2:0], store_nx[4]};
               dec.s    = {store_nx[3][2:0], store_nx[2]};
               dec.f    = {store_nx[1][2:0], store_nx[0]};
               if (store_nx[5][3] == 1'b0 && store_nx[3][3] == 1'b0 &&
                   store_nx[1][3] == 1'b0 &&
                   tc_valid(dec.rate, dec.h, dec.m, dec.s, dec.f)) begin
                  dec.compute = 1'b1;
                  dec.status  = ST_LOCKED;
               end else begin
                  dec        = '0;
                  dec.status = ST_INVALID;
                  dec.dir    = dir;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            store_ff[i] <= 4'd0;
         end
         rcv_ff  <= 8'd0;
         prev_ff <= 3'd0;
         seen_ff <= 1'b0;
      end else if (accept) begin
         if (clear) begin
            for (int i = 0; i < 8; i++) begin
               store_ff[i] <= 4'd0;
            end
            rcv_ff  <= 8'd0;
            prev_ff <= 3'd0;
            seen_ff <= 1'b0;
         end else begin
            if (wr_piece) begin
               store_ff[piece] <= nib;
            end
            rcv_ff  <= rcv_in;
            prev_ff <= prev_in;
            seen_ff <= seen_in;
         end
      end
   end

endmodule

/* sv/mtc_posunit.sv */
module mtc_posunit
   import mtc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dec_type     dec,
   input  logic [31:0] rate_num,
   input  logic [31:0] rate_den,
   output logic        done,
   output logic [62:0] position
);

   typedef enum logic [8:0] {
      P_IDLE = 9'b000000001,
      P_LAB1 = 9'b000000010,
      P_LAB2 = 9'b000000100,
      P_LAB3 = 9'b000001000,
      P_MA   = 9'b000010000,
      P_MB   = 9'b000100000,
      P_MC   = 9'b001000000,
      P_DIV  = 9'b010000000,
      P_FIN  = 9'b100000000
   } pstate_type;

   pstate_type  state_ff, state_in;
   dec_type     dec_ff;
   logic [10:0] tmin_ff;
   logic [16:0] tsec_ff;
   logic [11:0] drop_ff;
   logic [21:0] lab_ff;
   logic [63:0] mprod_ff;
   logic [46:0] dvsr_ff;
   logic [46:0] rem_ff;
   logic [63:0] quo_ff;
   logic [5:0]  cnt_ff;

   logic        is_drop;
   logic [4:0]  nom;
   logic [14:0] fr_num;
   logic [9:0]  fr_den;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [23:0] t10_mul;
   logic [7:0]  t10;
   logic [47:0] rem_sh;
   logic        qbit;
   logic [47:0] rem_sub;
   logic [64:0] qsum;

   assign is_drop = dec_ff.rate == RATE_DROP;
   assign nom     = nominal_fps(dec_ff.rate);
   assign fr_num  = is_drop ? DROP_FR_NUM : {10'd0, nom};
   assign fr_den  = is_drop ? DROP_FR_DEN : 10'd1;

   always_comb begin
      case (state_ff)
         P_MA: begin
            mul_a = {10'd0, lab_ff};
            mul_b = {22'd0, fr_den};
         end
         P_MB: begin
            mul_a = mprod_ff[31:0];
            mul_b = rate_num;
         end
         default: begin
            mul_a = rate_den;
            mul_b = {17'd0, fr_num};
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign t10_mul = 24'(tmin_ff) * 24'd6554;
   assign t10     = t10_mul[23:16];
   assign rem_sh  = {rem_ff, quo_ff[63]};
   assign rem_sub = rem_sh - {1'b0, dvsr_ff};
   assign qbit    = rem_sh >= {1'b0, dvsr_ff};
   assign qsum    = {1'b0, quo_ff} + 65'(rem_ff != 47'd0);

   assign done     = state_ff == P_FIN;
   assign position = (qsum[64:63] != 2'b00) ? {63{1'b1}} : qsum[62:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         P_IDLE:  if (start) state_in = P_LAB1;
         P_LAB1:  state_in = P_LAB2;
         P_LAB2:  state_in = P_LAB3;
         P_LAB3:  state_in = P_MA;
         P_MA:    state_in = P_MB;
         P_MB:    state_in = P_MC;
         P_MC:    state_in = P_DIV;
         P_DIV:   if (cnt_ff == 6'd63) state_in = P_FIN;
         P_FIN:   state_in = P_IDLE;
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         P_IDLE: begin
            dec_ff <= dec;
         end
         P_LAB1: begin
            tmin_ff <= 11'(dec_ff.h) * 11'd60 + 11'(dec_ff.m);
         end
         P_LAB2: begin
            tsec_ff <= 17'(tmin_ff) * 17'd60 + 17'(dec_ff.s);
            drop_ff <= 12'(2 * (12'(tmin_ff) - 12'(t10)));
         end
         P_LAB3: begin
            lab_ff <= 22'(tsec_ff) * 22'(nom) + 22'(dec_ff.f) -
                      (is_drop ? 22'(drop_ff) : 22'd0);
         end
         P_MA, P_MB: begin
            mprod_ff <= mul_p;
         end
         P_MC: begin
            dvsr_ff <= mul_p[46:0];
            quo_ff  <= mprod_ff;
            rem_ff  <= 47'd0;
            cnt_ff  <= 6'd0;
         end
         P_DIV: begin
            rem_ff <= qbit ? rem_sub[46:0] : rem_sh[46:0];
            quo_ff <= {quo_ff[62:0], qbit};
            cnt_ff <= cnt_ff + 6'd1;
         end
         default: begin
         end
      endcase
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("position sequencer state not one-hot");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == P_IDLE)
      else $error("start while sequencer busy");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == P_DIV && cnt_ff == 6'd63) |=> state_ff == P_FIN)
      else $error("division did not finish after 64 steps");
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == P_FIN |=> state_ff == P_IDLE)
      else $error("sequencer did not return to idle");

endmodule

/* sv/mtc_quarter_frame_chaser.sv */
// Status-only results are registered in the cycle after acceptance; locked
// results pass label arithmetic, three passes of the shared multiplier and
// a 64-step divider. One transaction per cycle for status-only results
// unless rsp_ready holds it; none is taken while the sequencer runs.
// Reset: synchronous, active high; clears piece store and tracking state,
// sets sample rate to 48000/1.
module mtc_quarter_frame_chaser
   import mtc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] num_ff, den_ff;
   logic        busy_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic        accept;
   logic        rate_ok;
   dec_type     dec;
   logic        done;
   logic [62:0] position;

   assign rate_ok   = (num_ff != 32'd0) && (den_ff != 32'd0);
   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   mtc_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rate_ok (rate_ok),
      .req     (req_data),
      .dec     (dec)
   );

   mtc_posunit u_posunit (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && dec.compute),
      .dec      (dec),
      .rate_num (num_ff),
      .rate_den (den_ff),
      .done     (done),
      .position (position)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= RATE_NUM_RESET;
         den_ff <= RATE_DEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE_NUM: num_ff <= csr_wdata;
            CSR_RATE_DEN: den_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff      <= dec.compute;
            rsp_valid_ff <= !dec.compute;
         end else if (done) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.status          <= dec.status;
         rsp_ff.direction       <= dec.dir;
         rsp_ff.rate_code       <= dec.rate;
         rsp_ff.tc_hours        <= dec.h;
         rsp_ff.tc_minutes      <= dec.m;
         rsp_ff.tc_seconds      <= dec.s;
         rsp_ff.tc_frames       <= dec.f;
         rsp_ff.sample_position <= 63'd0;
      end else if (done) begin
         rsp_ff.sample_position <= position;
      end
   end

endmodule

/* bench/tb_mtc_quarter_frame_chaser.sv */
module tb_mtc_quarter_frame_chaser;
   import mtc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = CSR_RATE_NUM;
   logic [31:0] csr_wdata = '0;

   mtc_quarter_frame_chaser i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // chaser model state
   logic [3:0]  pieces [8];
   logic [7:0]  got_mask;
   logic [2:0]  last_piece;
   logic        last_seen;
   logic [31:0] rate_num;
   logic [31:0] rate_den;

   req_type pending_q [$];
   rsp_type timecode_q [$];
   int      n_errors = 0;
   int      n_locked = 0;
   int      n_rsp = 0;
   longint  cycle = 0;
   bit      drive_en = 1'b0;
   int      req_gap = 0;
   int      rsp_gap = 0;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   function automatic int fps_of(logic [1:0] rc);
      return (rc == RATE_24) ? 24 : (rc == RATE_25) ? 25 : 30;
   endfunction

   function automatic bit tc_ok(logic [1:0] rc, int h, int m, int s, int f);
      if (h >= 24 || m >= 60 || s >= 60 || f >= fps_of(rc)) return 0;
      if (rc == RATE_DROP && s == 0 && (m % 10) != 0 && f < 2) return 0;
      return 1;
   endfunction

   function automatic rsp_type lock_rsp(logic [1:0] dir, logic [1:0] rc,
                                        int h, int m, int s, int f);
      rsp_type r;
      logic [127:0] prod, div, q;
      longint unsigned tmin, lab, fnum, fden;
      r = '0;
      tmin = h * 60 + m;
      lab = (tmin * 60 + s) * fps_of(rc) + f;
      fnum = fps_of(rc);
      fden = 1;
      if (rc == RATE_DROP) begin
         lab = lab - 2 * (tmin - tmin / 10);
         fnum = DROP_FR_NUM;
         fden = DROP_FR_DEN;
      end
      prod = 128'(lab) * 128'(fden) * 128'(rate_num);
      div = 128'(rate_den) * 128'(fnum);
      q = prod / div;
      if (prod % div != 0) q = q + 1;
      if (q > 128'h7FFF_FFFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF_FFFF;
      r.status = ST_LOCKED;
      r.direction = dir;
      r.rate_code = rc;
      r.tc_hours = 5'(h);
      r.tc_minutes = 7'(m);
      r.tc_seconds = 7'(s);
      r.tc_frames = 7'(f);
      r.sample_position = q[62:0];
      return r;
   endfunction

   function automatic void clear_pieces();
      for (int i = 0; i < 8; i++) pieces[i] = '0;
      got_mask = '0;
      last_piece = '0;
      last_seen = 1'b0;
   endfunction

   function automatic rsp_type chase_step(req_type t);
      rsp_type r;
      logic [2:0] p;
      logic [1:0] dir, rc;
      int h, m, s, f;
      r = '0;
      r.status = ST_INVALID;
      r.direction = DIR_UNKNOWN;
      if (rate_num == 0 || rate_den == 0) return r;
      if (t.action) begin
         rc = t.ff_rate_hours[6:5];
         h = t.ff_rate_hours[4:0];
         m = t.ff_minutes;
         s = t.ff_seconds;
         f = t.ff_frames;
         if (!tc_ok(rc, h, m, s, f)) return r;
         clear_pieces();
         return lock_rsp(DIR_UNKNOWN, rc, h, m, s, f);
      end
      p = t.qf_byte[6:4];
      if (p == 3'd7 && t.qf_byte[3]) begin
         clear_pieces();
         return r;
      end
      dir = DIR_UNKNOWN;
      if (last_seen) begin
         if (p == last_piece + 3'd1) dir = DIR_FORWARD;
         else if (p == last_piece - 3'd1) dir = DIR_REVERSE;
         else begin
            pieces[p] = t.qf_byte[3:0];
            got_mask = 8'(1) << p;
            last_piece = p;
            r.status = ST_DISCONT;
            return r;
         end
      end
      pieces[p] = t.qf_byte[3:0];
      got_mask = got_mask | (8'(1) << p);
      last_piece = p;
      last_seen = 1'b1;
      r.direction = dir;
      if (!(got_mask == 8'hff && ((dir == DIR_FORWARD && p == 3'd7) ||
                                  (dir == DIR_REVERSE && p == 3'd0)))) begin
         r.status = ST_INCOMPLETE;
         return r;
      end
      f = {pieces[1], pieces[0]};
      s = {pieces[3], pieces[2]};
      m = {pieces[5], pieces[4]};
      h = {pieces[7][0], pieces[6]};
      rc = pieces[7][2:1];
      got_mask = '0;
      if (!tc_ok(rc, h, m, s, f)) return r;
      return lock_rsp(dir, rc, h, m, s, f);
   endfunction

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 3000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         timecode_q.push_back(chase_step(req_data));
         req_gap = gap_len();
         if (req_gap == 0 && drive_en && pending_q.size() > 0) begin
            req_data <= pending_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid && drive_en && pending_q.size() > 0) begin
         if (req_gap > 0) req_gap--;
         else begin
            req_data <= pending_q.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (timecode_q.size() == 0) begin
            $error("unexpected transaction %h", rsp_data);
            n_errors++;
         end else begin
            e = timecode_q.pop_front();
            if (e.status == ST_LOCKED) n_locked++;
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status); n_errors++; end
            if (rsp_data.direction !== e.direction) begin
               $error("direction exp %0d got %0d", e.direction, rsp_data.direction);
               n_errors++; end
            if (rsp_data.rate_code !== e.rate_code) begin
               $error("rate_code exp %0d got %0d", e.rate_code, rsp_data.rate_code);
               n_errors++; end
            if (rsp_data.tc_hours !== e.tc_hours) begin
               $error("tc_hours exp %0d got %0d", e.tc_hours, rsp_data.tc_hours);
               n_errors++; end
            if (rsp_data.tc_minutes !== e.tc_minutes) begin
               $error("tc_minutes exp %0d got %0d", e.tc_minutes, rsp_data.tc_minutes);
               n_errors++; end
            if (rsp_data.tc_seconds !== e.tc_seconds) begin
               $error("tc_seconds exp %0d got %0d", e.tc_seconds, rsp_data.tc_seconds);
               n_errors++; end
            if (rsp_data.tc_frames !== e.tc_frames) begin
               $error("tc_frames exp %0d got %0d", e.tc_frames, rsp_data.tc_frames);
               n_errors++; end
            if (rsp_data.sample_position !== e.sample_position) begin
               $error("sample_position exp %0d got %0d", e.sample_position,
                      rsp_data.sample_position);
               n_errors++; end
         end
      end
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_gap = gap_len();
         rsp_ready <= (rsp_gap == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type qf(int p, int nib);
      req_type t;
      t = '0;
      t.action = 1'b0;
      t.qf_byte = {3'(p), 4'(nib)};
      return t;
   endfunction

   function automatic req_type ff(int rc, int h, int m, int s, int f);
      req_type t;
      t = '0;
      t.action = 1'b1;
      t.ff_rate_hours = {2'(rc), 5'(h)};
      t.ff_minutes = 7'(m);
      t.ff_seconds = 7'(s);
      t.ff_frames = 7'(f);
      return t;
   endfunction

   task automatic queue_cycle(bit rev, int rc, int h, int m, int s, int f);
      logic [3:0] nb [8];
      nb[0] = f[3:0]; nb[1] = f[7:4]; nb[2] = s[3:0]; nb[3] = s[7:4];
      nb[4] = m[3:0]; nb[5] = m[7:4]; nb[6] = h[3:0];
      nb[7] = {1'b0, 2'(rc), 1'(h >> 4)};
      for (int i = 0; i < 8; i++) begin
         if (rev) pending_q.push_back(qf(7 - i, nb[7 - i]));
         else pending_q.push_back(qf(i, nb[i]));
      end
   endtask

   task automatic random_tc(output int rc, output int h, output int m,
                            output int s, output int f);
      rc = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) begin
         h = $urandom_range(0, 31); m = $urandom_range(0, 127);
         s = $urandom_range(0, 127); f = $urandom_range(0, 127);
      end else begin
         h = $urandom_range(0, 23); m = $urandom_range(0, 59);
         s = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 59);
         f = $urandom_range(0, fps_of(2'(rc)) - 1);
         if ($urandom_range(0, 3) == 0) f = $urandom_range(0, 2);
      end
   endtask

   task automatic wait_idle();
      while (pending_q.size() > 0 || req_valid || timecode_q.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(logic [0:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_RATE_NUM) rate_num = val;
      else rate_den = val;
   endtask

   task automatic random_phase(int n);
      int rc, h, m, s, f, k;
      req_type t;
      drive_en = 1'b0;
      for (int i = 0; i < n; ) begin
         k = $urandom_range(0, 9);
         random_tc(rc, h, m, s, f);
         if (k < 6) begin
            queue_cycle(k[0], rc, h, m, s, f);
            i += 8;
            if ($urandom_range(0, 1)) begin
               queue_cycle(k[0], rc, h, m, s, f);
               i += 8;
            end
         end else if (k < 8) begin
            pending_q.push_back(ff(rc, h, m, s, f));
            i++;
         end else begin
            t.action = 1'($urandom);
            t.qf_byte = 7'($urandom);
            t.ff_rate_hours = 7'($urandom);
            t.ff_minutes = 7'($urandom);
            t.ff_seconds = 7'($urandom);
            t.ff_frames = 7'($urandom);
            pending_q.push_back(t);
            i++;
         end
      end
      drive_en = 1'b1;
      wait_idle();
   endtask

   initial begin
      clear_pieces();
      rate_num = RATE_NUM_RESET;
      rate_den = RATE_DEN_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, both directions, drop-frame rule, reserved bit, jump
      pending_q.push_back(ff(RATE_30, 23, 59, 59, 29));
      pending_q.push_back(ff(RATE_24, 0, 0, 0, 0));
      pending_q.push_back(ff(RATE_DROP, 0, 1, 0, 1));
      pending_q.push_back(ff(RATE_DROP, 0, 10, 0, 0));
      pending_q.push_back(ff(3, 31, 127, 127, 127));
      queue_cycle(0, RATE_25, 23, 59, 59, 24);
      queue_cycle(1, RATE_DROP, 12, 34, 56, 7);
      pending_q.push_back(qf(3, 5));
      pending_q.push_back(qf(7, 8));
      pending_q.push_back(qf(2, 15));
      pending_q.push_back(qf(6, 0));
      drive_en = 1'b1;
      wait_idle();
      random_phase(300);
      csr_write(CSR_RATE_NUM, 32'hFFFF_FFFF);
      csr_write(CSR_RATE_DEN, 32'd1);
      random_phase(200);
      csr_write(CSR_RATE_NUM, 32'd1);
      csr_write(CSR_RATE_DEN, 32'hFFFF_FFFF);
      random_phase(150);
      csr_write(CSR_RATE_NUM, 32'd0);
      random_phase(30);
      csr_write(CSR_RATE_NUM, $urandom);
      csr_write(CSR_RATE_DEN, 32'd0);
      random_phase(30);
      csr_write(CSR_RATE_NUM, $urandom);
      csr_write(CSR_RATE_DEN, $urandom_range(1, 100000));
      random_phase(300);
      $display("Checked %0d transactions, %0d locked, over six rate settings",
               n_rsp, n_locked);
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
